>>> sv/tssrb_pkg.sv
// shared types, codes and helpers for the three-stack ring buffer
package tssrb_pkg;

  // fixed field widths
  localparam int unsigned NUM_STACKS     = 3;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned SID_W          = 2;
  localparam int unsigned IO_W           = 32;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned WORD_MAX_W     = 64;

  // parameter defaults
  localparam int unsigned SLOTS_EACH_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // direction of one ring pointer step
  typedef enum logic {
    RING_INC = 1'b0,
    RING_DEC = 1'b1
  } ring_dir_e;

  // one finished result handed from the sequencer to the output register
  typedef struct packed {
    logic [IO_W-1:0] read_value;
    status_e         status;
  } res_t;

  // next stack around the ring
  function automatic logic [SID_W-1:0] next_stack(input logic [SID_W-1:0] s);
    return (s == SID_W'(NUM_STACKS - 1)) ? '0 : s + SID_W'(1);
  endfunction

endpackage

>>> sv/tssrb_ram.sv
// generic single-write, single-read ram with registered read data
module tssrb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tssrb_ring_unit.sv
// shared ring pointer unit: one step up or down modulo the store depth
module tssrb_ring_unit #(
  parameter int unsigned DEPTH = 48
) (
  input  logic [$clog2(DEPTH)-1:0] a_i,
  input  tssrb_pkg::ring_dir_e     dir_i,
  output logic [$clog2(DEPTH)-1:0] y_o
);
  import tssrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // wrap at the ends of the ring
  always_comb begin
    if (dir_i == RING_INC) begin
      y_o = (a_i == AW'(DEPTH - 1)) ? '0 : a_i + AW'(1);
    end else begin
      y_o = (a_i == '0) ? AW'(DEPTH - 1) : a_i - AW'(1);
    end
  end

endmodule

>>> sv/tssrb_seq.sv
// sequencer: stack bookkeeping, borrow shifts and memory access steps
module tssrb_seq #(
  parameter int unsigned SLOTS_EACH = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned DEPTH     = 3 * SLOTS_EACH,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item intake
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tssrb_pkg::OP_W-1:0]    op_i,
  input  logic [tssrb_pkg::SID_W-1:0]   stack_id_i,
  input  logic [tssrb_pkg::IO_W-1:0]    push_value_i,
  // result handoff
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tssrb_pkg::res_t               res_o,
  // word store
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [DATA_WIDTH-1:0]         mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]         mem_rdata_i
);
  import tssrb_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned UW = CW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_WAIT,
    S_SH_INIT,
    S_SH_RD,
    S_SH_WR,
    S_SH_BOT,
    S_SH_TOP,
    S_PUSH,
    S_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [SID_W-1:0]     sid_q, sid_d;
  logic [IO_W-1:0]      val_q, val_d;
  logic [AW-1:0]        bot_q [NUM_STACKS];
  logic [AW-1:0]        bot_d [NUM_STACKS];
  logic [AW-1:0]        top_q [NUM_STACKS];
  logic [AW-1:0]        top_d [NUM_STACKS];
  logic [CW-1:0]        cap_q [NUM_STACKS];
  logic [CW-1:0]        cap_d [NUM_STACKS];
  logic [CW-1:0]        cnt_q [NUM_STACKS];
  logic [CW-1:0]        cnt_d [NUM_STACKS];
  logic [SID_W-1:0]     g_q, g_d;
  logic                 second_q, second_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        prev_q, prev_d;
  logic [CW-1:0]        k_q, k_d;
  logic [IO_W-1:0]      rd_q, rd_d;
  status_e              status_q, status_d;

  logic [AW-1:0]        ring_a;
  ring_dir_e            ring_dir;
  logic [AW-1:0]        ring_y;

  // the one ring step unit, shared by all steps of the sequencer
  tssrb_ring_unit #(
    .DEPTH (DEPTH)
  ) u_ring (
    .a_i   (ring_a),
    .dir_i (ring_dir),
    .y_o   (ring_y)
  );

  // push value fitted to the word width, read word fitted to the port
  logic [WORD_MAX_W-1:0] val_wide;
  logic [WORD_MAX_W-1:0] rdata_wide;

  always_comb begin
    val_wide                   = '0;
    val_wide[IO_W-1:0]         = val_q;
    rdata_wide                 = '0;
    rdata_wide[DATA_WIDTH-1:0] = mem_rdata_i;
  end

  // next-state and datapath control
  always_comb begin
    logic [SID_W-1:0] s;
    logic [SID_W-1:0] nx;
    logic [SID_W-1:0] nn;
    logic [UW-1:0]    used;

    s    = sid_q;
    nx   = next_stack(s);
    nn   = next_stack(nx);
    used = UW'(cnt_q[0]) + UW'(cnt_q[1]) + UW'(cnt_q[2]);

    state_d  = state_q;
    op_d     = op_q;
    sid_d    = sid_q;
    val_d    = val_q;
    bot_d    = bot_q;
    top_d    = top_q;
    cap_d    = cap_q;
    cnt_d    = cnt_q;
    g_d      = g_q;
    second_d = second_q;
    ptr_d    = ptr_q;
    prev_d   = prev_q;
    k_d      = k_q;
    rd_d     = rd_q;
    status_d = status_q;

    ring_a      = ptr_q;
    ring_dir    = RING_DEC;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ring_y;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          sid_d    = stack_id_i;
          val_d    = push_value_i;
          rd_d     = '0;
          status_d = ST_OK;
          state_d  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        ring_a   = top_q[s];
        ring_dir = RING_DEC;
        if (s == SID_W'(NUM_STACKS)) begin
          // stack id out of range: no effect
          state_d = S_FINISH;
        end else begin
          case (op_q)
            OP_PUSH: begin
              if (cnt_q[s] < cap_q[s]) begin
                state_d = S_PUSH;
              end else if (used >= UW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_FINISH;
              end else begin
                // borrow a slot from the next stack, or from the one after it
                cap_d[s] = cap_q[s] + CW'(1);
                if (cnt_q[nx] < cap_q[nx]) begin
                  g_d       = nx;
                  second_d  = 1'b0;
                  cap_d[nx] = cap_q[nx] - CW'(1);
                end else begin
                  g_d       = nn;
                  second_d  = 1'b1;
                  cap_d[nn] = cap_q[nn] - CW'(1);
                end
                state_d = S_SH_INIT;
              end
            end
            OP_POP, OP_PEEK: begin
              if (cnt_q[s] == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_FINISH;
              end else begin
                // read the word below the top
                prev_d  = ring_y;
                state_d = S_RD_WAIT;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        rd_d = rdata_wide[IO_W-1:0];
        if (op_q == OP_POP) begin
          top_d[s] = prev_q;
          cnt_d[s] = cnt_q[s] - CW'(1);
        end
        state_d = S_FINISH;
      end

      S_SH_INIT: begin
        ptr_d   = top_q[g_q];
        k_d     = cnt_q[g_q];
        state_d = (cnt_q[g_q] == '0) ? S_SH_BOT : S_SH_RD;
      end

      S_SH_RD: begin
        // fetch the word one place below the write pointer
        ring_a   = ptr_q;
        ring_dir = RING_DEC;
        prev_d   = ring_y;
        state_d  = S_SH_WR;
      end

      S_SH_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = mem_rdata_i;
        ptr_d       = prev_q;
        k_d         = k_q - CW'(1);
        state_d     = (k_q == CW'(1)) ? S_SH_BOT : S_SH_RD;
      end

      S_SH_BOT: begin
        ring_a       = bot_q[g_q];
        ring_dir     = RING_INC;
        bot_d[g_q]   = ring_y;
        state_d      = S_SH_TOP;
      end

      S_SH_TOP: begin
        ring_a     = top_q[g_q];
        ring_dir   = RING_INC;
        top_d[g_q] = ring_y;
        if (second_q) begin
          g_d      = nx;
          second_d = 1'b0;
          state_d  = S_SH_INIT;
        end else begin
          state_d = S_PUSH;
        end
      end

      S_PUSH: begin
        ring_a      = top_q[s];
        ring_dir    = RING_INC;
        mem_we_o    = 1'b1;
        mem_waddr_o = top_q[s];
        mem_wdata_o = val_wide[DATA_WIDTH-1:0];
        top_d[s]    = ring_y;
        cnt_d[s]    = cnt_q[s] + CW'(1);
        state_d     = S_FINISH;
      end

      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, stack bookkeeping, item payload and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        bot_q[i] <= AW'(i * SLOTS_EACH);
        top_q[i] <= AW'(i * SLOTS_EACH);
        cap_q[i] <= CW'(SLOTS_EACH);
        cnt_q[i] <= '0;
      end
      op_q     <= '0;
      sid_q    <= '0;
      val_q    <= '0;
      g_q      <= '0;
      ptr_q    <= '0;
      prev_q   <= '0;
      k_q      <= '0;
      rd_q     <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      bot_q    <= bot_d;
      top_q    <= top_d;
      cap_q    <= cap_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
      sid_q    <= sid_d;
      val_q    <= val_d;
      g_q      <= g_d;
      ptr_q    <= ptr_d;
      prev_q   <= prev_d;
      k_q      <= k_d;
      rd_q     <= rd_d;
      status_q <= status_d;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign res_valid_o      = (state_q == S_FINISH);
  assign res_o.read_value = rd_q;
  assign res_o.status     = status_q;

endmodule

>>> sv/three_stacks_shared_ring_buffer_core.sv
// top level: three stacks in one circular word store, stream ports
//
// Three stacks share one ring of 3*SLOTS_EACH words of DATA_WIDTH bits, each
// starting with an equal region. Every input item is a push, pop or peek on
// one stack and gives exactly one result item (read word and status). A push
// onto a stack at capacity borrows a slot from the next stack around the
// ring, or from the one after it, shifting the lender and any stack between
// up by one place. Items are handled one at a time by a sequencer around a
// single ring pointer unit and a one-read, one-write word memory. Pop and
// peek step through decide, read wait and finish, a plain push through
// decide, push and finish. A borrowing push first moves each stack it shifts
// word by word, a read and then a write per word, then steps its bottom and
// top pointers. An output register holds the finished result, so the block
// takes the next item while the result waits; with that register still full
// the sequencer holds its result and stalls.
module three_stacks_shared_ring_buffer_core #(
  parameter int unsigned SLOTS_EACH = tssrb_pkg::SLOTS_EACH_DEF,
  parameter int unsigned DATA_WIDTH = tssrb_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [31:0]           s_axis_tdata_i,   // [31:0] push_value
  input  logic [3:0]            s_axis_tuser_i,   // [1:0] op, [3:2] stack_id
  // result items
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [31:0]           m_axis_tdata_o,   // [31:0] read_value
  output logic [1:0]            m_axis_tuser_o    // [1:0] status
);
  import tssrb_pkg::*;

  localparam int unsigned DEPTH = 3 * SLOTS_EACH;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  out_valid_q;
  res_t                  out_q;

  // stack sequencer
  tssrb_seq #(
    .SLOTS_EACH (SLOTS_EACH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .op_i         (s_axis_tuser_i[1:0]),
    .stack_id_i   (s_axis_tuser_i[3:2]),
    .push_value_i (s_axis_tdata_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // shared word store
  tssrb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register between sequencer and result stream
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.read_value;
  assign m_axis_tuser_o  = out_q.status;

endmodule

>>> sv/tssrb_checker.sv
// port-level checks for the three-stack ring buffer, bound to the top level
module tssrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);
  import tssrb_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a failed operation returns a zero word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> m_axis_tdata_o == '0)
    else $error("nonzero read word with error status");

  // one item at a time: intake closes right after an accept
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("item accepted while previous item in progress");

  // no result without an item behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != '0)
    else $error("result delivered with no item pending");

  // at most one item in the sequencer and one in the output register
  a_pending_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many items in flight");

endmodule

bind three_stacks_shared_ring_buffer_core tssrb_checker u_tssrb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
